[sv/page_frame_cache_lru_fifo_top_assert.svh]
// ----------------------------------------------------------------------------
// page frame cache assertion macros
// shared assertion forms for the page frame cache modules
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_CACHE_LRU_FIFO_TOP_ASSERT_SVH
`define PAGE_FRAME_CACHE_LRU_FIFO_TOP_ASSERT_SVH

// same-cycle implication, checked on aclk outside reset
`define PFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define PFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pfc_pkg.sv]
// ----------------------------------------------------------------------------
// pfc_pkg
// types and constants shared by the page frame cache modules
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int PROCESS_W     = 16;
    localparam int PAGE_W        = 20;
    localparam int FRAME_W       = 20;
    localparam int STAMP_W       = 32;
    localparam int LIMIT_W       = 5;
    localparam int CFG_IDX_W     = 1;

    typedef enum logic [1:0] {
        CMD_LOOKUP_TOUCH = 2'd0,
        CMD_LOOKUP       = 2'd1,
        CMD_INSERT       = 2'd2,
        CMD_CLEAR        = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENTRIES_IN_USE = 1'd0,
        REG_POLICY_LRU     = 1'd1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // one table slot as held in the ram
    typedef struct packed {
        logic [PROCESS_W-1:0] process_id;
        logic [PAGE_W-1:0]    page_number;
        logic [FRAME_W-1:0]   frame;
        logic [STAMP_W-1:0]   last_use;
        logic [STAMP_W-1:0]   insert_order;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // control into the scan unit
    typedef struct packed {
        logic                 start;
        logic                 find_victim;
        logic                 policy_lru;
        logic [PROCESS_W-1:0] process_id;
        logic [PAGE_W-1:0]    page_number;
    } scan_ctl_t;

    // status out of the scan unit
    typedef struct packed {
        logic               done;
        logic               found;
        logic               inv_found;
        logic [FRAME_W-1:0] frame;
        logic [STAMP_W-1:0] insert_order;
    } scan_res_t;

endpackage

[sv/pfc_ram.sv]
// ----------------------------------------------------------------------------
// pfc_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module pfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/pfc_scan.sv]
// ----------------------------------------------------------------------------
// pfc_scan
// walks the table one slot per cycle, finding the earliest inserted match or the victim
// ----------------------------------------------------------------------------
module pfc_scan #(
    parameter int ENTRIES = pfc_pkg::ENTRIES_DEF,
    localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pfc_pkg::scan_ctl_t ctl,
    input  logic [ENTRIES-1:0] entry_valid,
    output logic               rd_en,
    output logic [IW-1:0]      rd_addr,
    input  pfc_pkg::entry_t    rd_entry,
    output pfc_pkg::scan_res_t res,
    output logic [IW-1:0]      best_idx,
    output logic [IW-1:0]      inv_idx
);

    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    logic                        issue_en_reg;
    logic [IW-1:0]               issue_idx_reg;
    logic                        cmp_vld_reg;
    logic [IW-1:0]               cmp_idx_reg;
    logic                        done_reg;
    logic                        found_reg;
    logic                        inv_found_reg;
    logic [IW-1:0]               best_idx_reg;
    logic [IW-1:0]               inv_idx_reg;
    logic [pfc_pkg::FRAME_W-1:0] best_frame_reg;
    logic [pfc_pkg::STAMP_W-1:0] best_last_reg;
    logic [pfc_pkg::STAMP_W-1:0] best_order_reg;

    logic slot_valid;
    logic key_match;
    logic older;
    logic better;
    logic take;

    always_comb begin
        slot_valid = entry_valid[cmp_idx_reg];
        key_match  = (rd_entry.process_id == ctl.process_id) &&
                     (rd_entry.page_number == ctl.page_number);
        older      = rd_entry.insert_order < best_order_reg;
        if (ctl.policy_lru) begin
            better = (rd_entry.last_use < best_last_reg) ||
                     ((rd_entry.last_use == best_last_reg) && older);
        end else begin
            better = older;
        end
        if (ctl.find_victim) begin
            take = slot_valid && (!found_reg || better);
        end else begin
            take = slot_valid && key_match && (!found_reg || older);
        end
    end

    // issue and compare control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_en_reg <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            cmp_vld_reg <= issue_en_reg;
            done_reg    <= cmp_vld_reg && (cmp_idx_reg == LAST);
            if (ctl.start) begin
                issue_en_reg <= 1'b1;
            end else if (issue_en_reg && (issue_idx_reg == LAST)) begin
                issue_en_reg <= 1'b0;
            end
        end
    end

    // running best and first free slot
    always_ff @(posedge aclk) begin
        cmp_idx_reg <= issue_idx_reg;
        if (ctl.start) begin
            issue_idx_reg <= '0;
            found_reg     <= 1'b0;
            inv_found_reg <= 1'b0;
        end else begin
            if (issue_en_reg) begin
                issue_idx_reg <= issue_idx_reg + 1'b1;
            end
            if (cmp_vld_reg) begin
                if (take) begin
                    found_reg      <= 1'b1;
                    best_idx_reg   <= cmp_idx_reg;
                    best_frame_reg <= rd_entry.frame;
                    best_last_reg  <= rd_entry.last_use;
                    best_order_reg <= rd_entry.insert_order;
                end
                if (!slot_valid && !inv_found_reg) begin
                    inv_found_reg <= 1'b1;
                    inv_idx_reg   <= cmp_idx_reg;
                end
            end
        end
    end

    assign rd_en            = issue_en_reg;
    assign rd_addr          = issue_idx_reg;
    assign res.done         = done_reg;
    assign res.found        = found_reg;
    assign res.inv_found    = inv_found_reg;
    assign res.frame        = best_frame_reg;
    assign res.insert_order = best_order_reg;
    assign best_idx         = best_idx_reg;
    assign inv_idx          = inv_idx_reg;

endmodule

[sv/page_frame_cache_lru_fifo_top.sv]
// ----------------------------------------------------------------------------
// page_frame_cache_lru_fifo_top
// fully associative page-to-frame translation cache, fifo or lru replacement
// ----------------------------------------------------------------------------
// A lookup or insert beat walks every slot of the table through the single
// read port of the slot ram, one slot per cycle: each address is issued,
// its registered read data is compared against the running best, and a
// done flag is registered after the last slot, ending the scan. A clear
// beat, and any lookup or insert while entries_in_use is zero, skips the
// walk and goes to the finish step. The next input beat can be taken
// the cycle after a result is loaded. One beat is worked on at a time; a
// finished result waits in the output register while the next input beat is
// taken and scanned. Every input beat yields exactly one result beat. Lookups
// return the frame of the earliest inserted match; inserts return hit 0.
// Configuration writes are taken at any time but must only be issued while
// the cache is idle.
// ----------------------------------------------------------------------------
`include "page_frame_cache_lru_fifo_top_assert.svh"

module page_frame_cache_lru_fifo_top #(
    parameter int ENTRIES = pfc_pkg::ENTRIES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pfc_pkg::LIMIT_W-1:0]      cfg_wdata,
    // command channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_command,
    input  logic [pfc_pkg::PROCESS_W-1:0]    s_process_id,
    input  logic [pfc_pkg::PAGE_W-1:0]       s_page_number,
    input  logic [pfc_pkg::FRAME_W-1:0]      s_frame_in,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_hit,
    output logic [pfc_pkg::FRAME_W-1:0]      m_frame_out
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    // wide enough for both the live count and the configured limit
    localparam int LW = (CW > pfc_pkg::LIMIT_W) ? CW : pfc_pkg::LIMIT_W;

    // fsm and beat capture
    pfc_pkg::state_t              state_reg, state_next;
    pfc_pkg::cmd_t                cmd_reg;
    logic [pfc_pkg::PROCESS_W-1:0] pid_reg;
    logic [pfc_pkg::PAGE_W-1:0]   page_reg;
    logic [pfc_pkg::FRAME_W-1:0]  frame_reg;
    logic                         act_reg;    // cache enabled when taken
    logic                         evict_reg;  // table at or above limit

    // table bookkeeping
    logic [ENTRIES-1:0]           valid_reg, valid_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [pfc_pkg::STAMP_W-1:0]  access_counter_reg, access_counter_next;

    // configuration
    logic [pfc_pkg::LIMIT_W-1:0]  entries_in_use_reg;
    logic                         policy_lru_reg;

    // output register
    logic                         m_valid_reg;
    logic                         m_hit_reg, m_hit_next;
    logic [pfc_pkg::FRAME_W-1:0]  m_frame_reg, m_frame_next;

    // datapath
    logic [LW-1:0]                limit;
    logic                         accept;
    logic                         out_free;
    logic                         finish_go;
    logic                         needs_scan;
    logic                         is_lookup;
    logic [IW-1:0]                free_idx;
    logic [IW-1:0]                best_idx;
    logic [IW-1:0]                inv_idx;
    pfc_pkg::scan_ctl_t           scan_ctl;
    pfc_pkg::scan_res_t           scan_res;

    // ram ports
    logic                         ram_wr_en;
    logic [IW-1:0]                ram_wr_addr;
    pfc_pkg::entry_t              ram_wr_entry;
    logic                         ram_rd_en;
    logic [IW-1:0]                ram_rd_addr;
    logic [pfc_pkg::ENTRY_W-1:0]  ram_rd_data;
    pfc_pkg::entry_t              ram_rd_entry;

    // oversized limit acts as the table size
    always_comb begin
        if (LW'(entries_in_use_reg) > LW'(ENTRIES)) begin
            limit = LW'(ENTRIES);
        end else begin
            limit = LW'(entries_in_use_reg);
        end
    end

    assign s_ready    = (state_reg == pfc_pkg::ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign finish_go  = (state_reg == pfc_pkg::ST_FINISH) && out_free;
    assign needs_scan = (pfc_pkg::cmd_t'(s_command) != pfc_pkg::CMD_CLEAR) &&
                        (limit != '0);

    // scan unit control
    assign scan_ctl.start       = accept && needs_scan;
    assign scan_ctl.find_victim = (cmd_reg == pfc_pkg::CMD_INSERT);
    assign scan_ctl.policy_lru  = policy_lru_reg;
    assign scan_ctl.process_id  = pid_reg;
    assign scan_ctl.page_number = page_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pfc_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = needs_scan ? pfc_pkg::ST_SCAN : pfc_pkg::ST_FINISH;
                end
            end
            pfc_pkg::ST_SCAN: begin
                if (scan_res.done) begin
                    state_next = pfc_pkg::ST_FINISH;
                end
            end
            pfc_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = pfc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfc_pkg::ST_IDLE;
            end
        endcase
    end

    // the new entry goes to the lowest free slot, counting the victim as freed
    always_comb begin
        if (evict_reg) begin
            if (scan_res.inv_found && (inv_idx < best_idx)) begin
                free_idx = inv_idx;
            end else begin
                free_idx = best_idx;
            end
        end else begin
            free_idx = inv_idx;
        end
    end

    // finish step: table update, ram write-back and result
    always_comb begin
        is_lookup           = cmd_reg inside {pfc_pkg::CMD_LOOKUP_TOUCH, pfc_pkg::CMD_LOOKUP};
        valid_next          = valid_reg;
        count_next          = count_reg;
        access_counter_next = access_counter_reg;
        ram_wr_en           = 1'b0;
        ram_wr_addr         = best_idx;
        ram_wr_entry.process_id   = pid_reg;
        ram_wr_entry.page_number  = page_reg;
        ram_wr_entry.frame        = scan_res.frame;
        ram_wr_entry.last_use     = access_counter_reg;
        ram_wr_entry.insert_order = scan_res.insert_order;
        m_hit_next          = act_reg && is_lookup && scan_res.found;
        m_frame_next        = m_hit_next ? scan_res.frame : '0;
        if (finish_go) begin
            case (cmd_reg)
                pfc_pkg::CMD_LOOKUP_TOUCH: begin
                    if (act_reg) begin
                        // stamp the matched slot and advance time, hit or miss
                        ram_wr_en           = scan_res.found;
                        access_counter_next = access_counter_reg + 1'b1;
                    end
                end
                pfc_pkg::CMD_LOOKUP: begin
                end
                pfc_pkg::CMD_INSERT: begin
                    if (act_reg) begin
                        if (evict_reg) begin
                            valid_next[best_idx] = 1'b0;
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                        valid_next[free_idx]      = 1'b1;
                        ram_wr_en                 = 1'b1;
                        ram_wr_addr               = free_idx;
                        ram_wr_entry.frame        = frame_reg;
                        ram_wr_entry.insert_order = access_counter_reg;
                        access_counter_next       = access_counter_reg + 1'b1;
                    end
                end
                pfc_pkg::CMD_CLEAR: begin
                    valid_next = '0;
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // state register and table control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= pfc_pkg::ST_IDLE;
            valid_reg          <= '0;
            count_reg          <= '0;
            access_counter_reg <= '0;
            entries_in_use_reg <= '0;
            policy_lru_reg     <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg          <= state_next;
            valid_reg          <= valid_next;
            count_reg          <= count_next;
            access_counter_reg <= access_counter_next;
            if (cfg_wr_en) begin
                case (pfc_pkg::reg_idx_t'(cfg_index))
                    pfc_pkg::REG_ENTRIES_IN_USE: entries_in_use_reg <= cfg_wdata;
                    pfc_pkg::REG_POLICY_LRU:     policy_lru_reg     <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (finish_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // beat capture and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= pfc_pkg::cmd_t'(s_command);
            pid_reg   <= s_process_id;
            page_reg  <= s_page_number;
            frame_reg <= s_frame_in;
            act_reg   <= (limit != '0);
            evict_reg <= (LW'(count_reg) >= limit);
        end
        if (finish_go) begin
            m_hit_reg   <= m_hit_next;
            m_frame_reg <= m_frame_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_hit       = m_hit_reg;
    assign m_frame_out = m_frame_reg;

    // slot storage
    pfc_ram #(
        .WIDTH (pfc_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign ram_rd_entry = pfc_pkg::entry_t'(ram_rd_data);

    // match and victim search
    pfc_scan #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (scan_ctl),
        .entry_valid (valid_reg),
        .rd_en       (ram_rd_en),
        .rd_addr     (ram_rd_addr),
        .rd_entry    (ram_rd_entry),
        .res         (scan_res),
        .best_idx    (best_idx),
        .inv_idx     (inv_idx)
    );

    // live count always agrees with the valid bits
    `PFC_ASSERT_NOW(a_count_matches_valid, 1'b1, count_reg == CW'($countones(valid_reg)), "live count out of step with valid bits")
    // the scan only reports completion while the fsm waits for it
    `PFC_ASSERT_NOW(a_done_in_scan, scan_res.done, state_reg == pfc_pkg::ST_SCAN, "scan finished outside scan state")
    // a finished beat always lands in the output register
    `PFC_ASSERT_NEXT(a_finish_loads_out, finish_go, m_valid_reg, "finished beat not presented")
    // time does not move while the table is being walked
    `PFC_ASSERT_NEXT(a_counter_held_in_scan, state_reg == pfc_pkg::ST_SCAN, $stable(access_counter_reg), "access counter moved during scan")

endmodule

[verif/page_frame_cache_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_frame_cache_checker
// watches the command and result channels of the page frame cache, keeps its
// own copy of the translation table and compares every result beat
// ----------------------------------------------------------------------------
module page_frame_cache_checker #(
    parameter int ENTRIES = pfc_pkg::ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfc_pkg::LIMIT_W-1:0]   cfg_wdata,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic [pfc_pkg::PROCESS_W-1:0] s_process_id,
    input  logic [pfc_pkg::PAGE_W-1:0]    s_page_number,
    input  logic [pfc_pkg::FRAME_W-1:0]   s_frame_in,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_hit,
    input  logic [pfc_pkg::FRAME_W-1:0]   m_frame_out,
    output int                            fail_count,
    output int                            pending,
    output int                            hits_seen,
    output int                            results_seen
);
    import pfc_pkg::*;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } translation_t;

    translation_t expected_translations[$];

    // shadow translation table
    logic                 slot_valid    [ENTRIES];
    logic [PROCESS_W-1:0] slot_process  [ENTRIES];
    logic [PAGE_W-1:0]    slot_page     [ENTRIES];
    logic [FRAME_W-1:0]   slot_frame    [ENTRIES];
    logic [STAMP_W-1:0]   slot_last_use [ENTRIES];
    logic [STAMP_W-1:0]   slot_inserted [ENTRIES];
    logic [STAMP_W-1:0]   use_counter;
    logic [LIMIT_W-1:0]   limit_reg;
    logic                 lru_reg;

    function automatic translation_t predict_translation(
        input cmd_t                 cmd,
        input logic [PROCESS_W-1:0] pid,
        input logic [PAGE_W-1:0]    page,
        input logic [FRAME_W-1:0]   frame
    );
        translation_t res;
        int           lim;
        int           hit_slot;
        int           victim;
        int           live;
        bit           placed;
        res      = '0;
        lim      = (limit_reg > ENTRIES) ? ENTRIES : int'(limit_reg);
        hit_slot = -1;
        victim   = -1;
        live     = 0;
        placed   = 1'b0;
        case (cmd)
            CMD_LOOKUP_TOUCH, CMD_LOOKUP: begin
                if (lim != 0) begin
                    // earliest inserted match wins
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (slot_valid[i] && slot_process[i] == pid && slot_page[i] == page) begin
                            if (hit_slot < 0 || slot_inserted[i] < slot_inserted[hit_slot])
                                hit_slot = i;
                        end
                    end
                    if (hit_slot >= 0) begin
                        res.hit   = 1'b1;
                        res.frame = slot_frame[hit_slot];
                        if (cmd == CMD_LOOKUP_TOUCH)
                            slot_last_use[hit_slot] = use_counter;
                    end
                    if (cmd == CMD_LOOKUP_TOUCH)
                        use_counter = use_counter + 1'b1;
                end
            end
            CMD_INSERT: begin
                if (lim != 0) begin
                    for (int i = 0; i < ENTRIES; i++)
                        live += slot_valid[i] ? 1 : 0;
                    if (live >= lim) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (slot_valid[i]) begin
                                if (victim < 0) begin
                                    victim = i;
                                end else if (lru_reg) begin
                                    if (slot_last_use[i] < slot_last_use[victim] ||
                                        (slot_last_use[i] == slot_last_use[victim] &&
                                         slot_inserted[i] < slot_inserted[victim]))
                                        victim = i;
                                end else if (slot_inserted[i] < slot_inserted[victim]) begin
                                    victim = i;
                                end
                            end
                        end
                        if (victim >= 0)
                            slot_valid[victim] = 1'b0;
                    end
                    // lowest free slot takes the new entry
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!placed && !slot_valid[i]) begin
                            slot_valid[i]    = 1'b1;
                            slot_process[i]  = pid;
                            slot_page[i]     = page;
                            slot_frame[i]    = frame;
                            slot_last_use[i] = use_counter;
                            slot_inserted[i] = use_counter;
                            placed           = 1'b1;
                        end
                    end
                    use_counter = use_counter + 1'b1;
                end
            end
            default: begin
                for (int i = 0; i < ENTRIES; i++)
                    slot_valid[i] = 1'b0;
            end
        endcase
        return res;
    endfunction

    initial begin
        fail_count   = 0;
        pending      = 0;
        hits_seen    = 0;
        results_seen = 0;
    end

    always @(posedge aclk) begin
        translation_t exp;
        int           errs;
        errs = 0;
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_valid[i]    = 1'b0;
                slot_process[i]  = '0;
                slot_page[i]     = '0;
                slot_frame[i]    = '0;
                slot_last_use[i] = '0;
                slot_inserted[i] = '0;
            end
            use_counter = '0;
            limit_reg   = '0;
            lru_reg     = 1'b0;
            expected_translations.delete();
        end else begin
            if (cfg_wr_en) begin
                case (reg_idx_t'(cfg_index))
                    REG_ENTRIES_IN_USE: limit_reg = cfg_wdata;
                    REG_POLICY_LRU:     lru_reg   = cfg_wdata[0];
                    default: ;
                endcase
            end
            // result side first: it can only answer an older command beat
            if (m_valid && m_ready) begin
                if (expected_translations.size() == 0) begin
                    $error("result beat with nothing pending: hit %0d frame_out 0x%05h",
                           m_hit, m_frame_out);
                    errs++;
                end else begin
                    exp = expected_translations.pop_front();
                    if (m_hit !== exp.hit) begin
                        $error("hit mismatch: expected %0d actual %0d", exp.hit, m_hit);
                        errs++;
                    end
                    if (m_frame_out !== exp.frame) begin
                        $error("frame_out mismatch: expected 0x%05h actual 0x%05h",
                               exp.frame, m_frame_out);
                        errs++;
                    end
                end
                results_seen <= results_seen + 1;
                if (m_hit === 1'b1)
                    hits_seen <= hits_seen + 1;
            end
            if (s_valid && s_ready)
                expected_translations.push_back(predict_translation(cmd_t'(s_command),
                    s_process_id, s_page_number, s_frame_in));
        end
        fail_count <= fail_count + errs;
        pending    <= expected_translations.size();
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives directed and random translation commands into the page frame cache
// under a range of limits and both replacement policies, with random idling
// on both channels, and reports the checker's verdict
// ----------------------------------------------------------------------------
module tb;
    import pfc_pkg::*;

    localparam int STALL_LIMIT = 2000;   // cycles with no beat before giving up
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int N_PHASES    = 10;
    localparam int POOL_SIZE   = 20;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [LIMIT_W-1:0]   cfg_wdata     = '0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_command     = '0;
    logic [PROCESS_W-1:0] s_process_id  = '0;
    logic [PAGE_W-1:0]    s_page_number = '0;
    logic [FRAME_W-1:0]   s_frame_in    = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic                 m_hit;
    logic [FRAME_W-1:0]   m_frame_out;

    int chk_failures;
    int chk_pending;
    int chk_hits;
    int chk_results;

    // idling controls, changed only at clock edges
    bit src_idle_on  = 1'b0;
    bit sink_idle_on = 1'b0;
    bit hold_req     = 1'b0;

    int stall_cycles = 0;

    // phase settings: limit and policy, the extremes among them
    int phase_entries [N_PHASES] = '{16, 1, 2, 5, 31, 8, 0, 3, 16, 12};
    bit phase_lru     [N_PHASES] = '{0, 1, 0, 1, 0, 1, 1, 1, 1, 0};

    // key pool so that lookups find what was inserted
    logic [PROCESS_W-1:0] pool_pid  [POOL_SIZE];
    logic [PAGE_W-1:0]    pool_page [POOL_SIZE];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    page_frame_cache_lru_fifo_top #(
        .ENTRIES (ENTRIES_DEF)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_process_id  (s_process_id),
        .s_page_number (s_page_number),
        .s_frame_in    (s_frame_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_frame_out   (m_frame_out)
    );

    page_frame_cache_checker #(
        .ENTRIES (ENTRIES_DEF)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_process_id  (s_process_id),
        .s_page_number (s_page_number),
        .s_frame_in    (s_frame_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_frame_out   (m_frame_out),
        .fail_count    (chk_failures),
        .pending       (chk_pending),
        .hits_seen     (chk_hits),
        .results_seen  (chk_results)
    );

    // offer one command beat and return at the edge where it is taken;
    // called at a clock edge, so valid only drops when a gap is inserted
    task automatic send_beat(
        input cmd_t                 cmd,
        input logic [PROCESS_W-1:0] pid,
        input logic [PAGE_W-1:0]    page,
        input logic [FRAME_W-1:0]   frame
    );
        int gap;
        gap = 0;
        if (src_idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_process_id  <= pid;
        s_page_number <= page;
        s_frame_in    <= frame;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop offering and wait until every result beat has been taken; one edge
    // first so the count includes the beat taken at this edge
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (chk_pending != 0) @(posedge aclk);
    endtask

    // both registers, written back to back while the cache is idle
    task automatic set_config(input int limit, input bit lru);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_ENTRIES_IN_USE;
        cfg_wdata <= limit[LIMIT_W-1:0];
        @(posedge aclk);
        cfg_index <= REG_POLICY_LRU;
        cfg_wdata <= {{(LIMIT_W-1){1'b0}}, lru};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // receiver: random stalls, plus one long hold-off counted here
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // watchdog: cycles in which neither channel moves a beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        int                   lim;
        int                   psize;
        int                   n_items;
        int                   r;
        int                   k;
        cmd_t                 cmd;
        logic [PROCESS_W-1:0] pid;
        logic [PAGE_W-1:0]    page;

        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_pid[i]  = PROCESS_W'($urandom);
            pool_page[i] = PAGE_W'($urandom);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        src_idle_on  <= 1'b1;
        sink_idle_on <= 1'b1;

        // cache disabled after reset: everything misses, inserts are dropped
        send_beat(CMD_LOOKUP_TOUCH, 16'h0000, 20'h00000, 20'h00000);
        send_beat(CMD_INSERT, 16'hFFFF, 20'hFFFFF, 20'hFFFFF);
        send_beat(CMD_LOOKUP, 16'hFFFF, 20'hFFFFF, 20'h00000);
        send_beat(CMD_CLEAR, 16'hFFFF, 20'hFFFFF, 20'hFFFFF);

        // fifo with three slots: duplicates, misses, oldest evicted first
        drain_results();
        set_config(3, 1'b0);
        send_beat(CMD_INSERT, 16'h0000, 20'h00000, 20'h00000);
        send_beat(CMD_INSERT, 16'hFFFF, 20'hFFFFF, 20'hFFFFF);
        send_beat(CMD_INSERT, 16'hFFFF, 20'hFFFFF, 20'h5A5A5);
        send_beat(CMD_LOOKUP_TOUCH, 16'hFFFF, 20'hFFFFF, 20'h00000);
        send_beat(CMD_LOOKUP, 16'h0000, 20'h00000, 20'hFFFFF);
        send_beat(CMD_LOOKUP, 16'h0000, 20'h00001, 20'h00000);
        send_beat(CMD_INSERT, 16'h1234, 20'h80000, 20'h0F0F0);
        send_beat(CMD_LOOKUP, 16'h0000, 20'h00000, 20'h00000);
        send_beat(CMD_LOOKUP_TOUCH, 16'hFFFF, 20'hFFFFF, 20'h00000);
        send_beat(CMD_CLEAR, 16'h0000, 20'h00000, 20'h00000);
        send_beat(CMD_LOOKUP, 16'hFFFF, 20'hFFFFF, 20'h00000);

        // lru with three slots: a touched entry survives the eviction
        drain_results();
        set_config(3, 1'b1);
        send_beat(CMD_INSERT, 16'h000A, 20'h0000A, 20'hA0A0A);
        send_beat(CMD_INSERT, 16'h000B, 20'h0000B, 20'hB0B0B);
        send_beat(CMD_INSERT, 16'h000C, 20'h0000C, 20'hC0C0C);
        send_beat(CMD_LOOKUP_TOUCH, 16'h000A, 20'h0000A, 20'h00000);
        send_beat(CMD_INSERT, 16'h000D, 20'h0000D, 20'hD0D0D);
        send_beat(CMD_LOOKUP, 16'h000B, 20'h0000B, 20'h00000);
        send_beat(CMD_LOOKUP, 16'h000A, 20'h0000A, 20'h00000);

        // limit dropped below the live count: one eviction per insert only
        drain_results();
        set_config(1, 1'b1);
        send_beat(CMD_INSERT, 16'h000E, 20'h0000E, 20'hE0E0E);
        send_beat(CMD_LOOKUP, 16'h000C, 20'h0000C, 20'h00000);
        send_beat(CMD_LOOKUP, 16'h000A, 20'h0000A, 20'h00000);

        // random phases, one register setting each
        for (int p = 0; p < N_PHASES; p++) begin
            // some phases run without idling; the last part has none at all
            src_idle_on  <= (p < 8) && (p % 3 != 2);
            sink_idle_on <= (p < 8) && (p % 4 != 1);
            drain_results();
            set_config(phase_entries[p], phase_lru[p]);
            if (p == 2)
                hold_req <= 1'b1;
            lim     = (phase_entries[p] > ENTRIES_DEF) ? ENTRIES_DEF : phase_entries[p];
            psize   = (lim + 3 > POOL_SIZE) ? POOL_SIZE : lim + 3;
            n_items = (phase_entries[p] == 0) ? 30 : 100;
            for (int j = 0; j < n_items; j++) begin
                // sender pause until the cache has answered everything
                if (p == 4 && j == 50)
                    drain_results();
                r    = $urandom_range(0, 99);
                k    = $urandom_range(0, psize - 1);
                pid  = pool_pid[k];
                page = pool_page[k];
                if (r < 3) begin
                    cmd  = CMD_CLEAR;
                    pid  = PROCESS_W'($urandom);
                    page = PAGE_W'($urandom);
                end else if (r < 40) begin
                    // now and then a fresh key replaces a pool entry
                    if ($urandom_range(0, 3) == 0) begin
                        pool_pid[k]  = PROCESS_W'($urandom);
                        pool_page[k] = PAGE_W'($urandom);
                        pid          = pool_pid[k];
                        page         = pool_page[k];
                    end
                    cmd = CMD_INSERT;
                end else if (r < 80) begin
                    cmd = $urandom_range(0, 1) ? CMD_LOOKUP_TOUCH : CMD_LOOKUP;
                end else if (r < 88) begin
                    // near miss: one bit off in the process or the page
                    cmd = $urandom_range(0, 1) ? CMD_LOOKUP_TOUCH : CMD_LOOKUP;
                    if ($urandom_range(0, 1))
                        pid = pid ^ (16'd1 << $urandom_range(0, PROCESS_W - 1));
                    else
                        page = page ^ (20'd1 << $urandom_range(0, PAGE_W - 1));
                end else begin
                    // noise: anything at all
                    cmd  = cmd_t'($urandom_range(0, 3));
                    pid  = PROCESS_W'($urandom);
                    page = PAGE_W'($urandom);
                end
                send_beat(cmd, pid, page, FRAME_W'($urandom));
            end
        end

        // let the last results out, then watch for strays
        drain_results();
        repeat (40) @(posedge aclk);

        $display("run covered %0d translation beats, %0d of them hits,", chk_results, chk_hits);
        $display("over %0d register settings with fifo and lru replacement", N_PHASES + 4);
        if (chk_failures == 0 && chk_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/pfc_pkg.sv
sv/pfc_ram.sv
sv/pfc_scan.sv
sv/page_frame_cache_lru_fifo_top.sv
verif/page_frame_cache_checker.sv
verif/tb.sv
